// File: rtl/core/text_console_writer_unit_defines.svh
// Assertion macros shared by the checker of the text console writer.
// No dependencies; included by name where assertions are written.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle while reset is low.
`define TXCW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console writer: assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define TXCW_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("text console writer: assertion failed");

`endif

// File: rtl/core/txcw_pkg.sv
// Types and constants of the text console writer.
// No dependencies; used by every module of the block.
package txcw_pkg;

   localparam int COL_W      = 7;
   localparam int ROW_W      = 6;
   localparam int ROW_PORT_W = 5;

   localparam logic [1:0] CMD_PUT  = 2'd0;
   localparam logic [1:0] CMD_SET  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_PUT  = 3'd1;
   localparam logic [2:0] OP_LF   = 3'd2;
   localparam logic [2:0] OP_CR   = 3'd3;
   localparam logic [2:0] OP_SET  = 3'd4;
   localparam logic [2:0] OP_READ = 3'd5;

   localparam logic [7:0] CODE_LF         = 8'd10;
   localparam logic [7:0] CODE_CR         = 8'd13;
   localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
   localparam logic [7:0] RESET_ATTR      = 8'h0F;

   localparam logic CSR_TALL_MODE = 1'b0;
   localparam logic CSR_TEXT_ATTR = 1'b1;

   typedef struct packed {
      logic [2:0]       op;
      logic [7:0]       char_code;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } txcw_item_type;

   typedef struct packed {
      logic [7:0]       cell_char;
      logic [7:0]       cell_attr;
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
      logic             scrolled;
   } txcw_rsp_type;

endpackage

// File: rtl/core/txcw_front.sv
// Front of the text console writer: takes words, decodes and clamps them,
// and holds them in a two-entry queue for the back. Depends on txcw_pkg.
module txcw_front #(
   parameter int COLUMNS     = 80,
   parameter int ROWS_TALL   = 32,
   parameter int ROWS_NORMAL = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [1:0]                     req_cmd,
   input  logic [7:0]                     req_char_code,
   input  logic [txcw_pkg::COL_W-1:0]     req_col,
   input  logic [txcw_pkg::ROW_PORT_W-1:0] req_row,
   input  logic                           tall_mode,
   input  logic                           init_busy,
   output logic                           q_valid,
   output txcw_pkg::txcw_item_type        q_item,
   input  logic                           q_pop
);

   txcw_pkg::txcw_item_type q_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              cnt_ff, cnt_in;
   txcw_pkg::txcw_item_type item;
   logic [txcw_pkg::ROW_W-1:0] rows_last;
   logic [txcw_pkg::ROW_W-1:0] row_wide;
   logic                    push_ok;

   assign rows_last = tall_mode ? txcw_pkg::ROW_W'(ROWS_TALL - 1)
                                : txcw_pkg::ROW_W'(ROWS_NORMAL - 1);
   assign row_wide  = txcw_pkg::ROW_W'(req_row);

   always_comb begin
      item.char_code = req_char_code;
      item.col = (req_col > txcw_pkg::COL_W'(COLUMNS - 1)) ?
                 txcw_pkg::COL_W'(COLUMNS - 1) : req_col;
      item.row = (row_wide > rows_last) ? rows_last : row_wide;
      case (req_cmd)
         txcw_pkg::CMD_PUT: begin
            if (req_char_code >= txcw_pkg::FIRST_PRINTABLE) begin
               item.op = txcw_pkg::OP_PUT;
            end else if (req_char_code == txcw_pkg::CODE_LF) begin
               item.op = txcw_pkg::OP_LF;
            end else if (req_char_code == txcw_pkg::CODE_CR) begin
               item.op = txcw_pkg::OP_CR;
            end else begin
               item.op = txcw_pkg::OP_NONE;
            end
         end
         txcw_pkg::CMD_SET:  item.op = txcw_pkg::OP_SET;
         txcw_pkg::CMD_READ: item.op = txcw_pkg::OP_READ;
         default:            item.op = txcw_pkg::OP_NONE;
      endcase
   end

   assign req_full = (cnt_ff == 2'd2) || init_busy;
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: rtl/core/txcw_back.sv
// Back of the text console writer: owns the screen memory and the cursor,
// carries out decoded words, scrolls and holds the result. Depends on txcw_pkg.
module txcw_back #(
   parameter int COLUMNS     = 80,
   parameter int ROWS_TALL   = 32,
   parameter int ROWS_NORMAL = 25
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tall_mode,
   input  logic [7:0]              text_attr,
   input  logic                    q_valid,
   input  txcw_pkg::txcw_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   output txcw_pkg::txcw_rsp_type  rsp,
   input  logic                    rsp_pop,
   output logic                    init_busy
);

   localparam int ROW_CAP    = (ROWS_TALL > ROWS_NORMAL) ? ROWS_TALL : ROWS_NORMAL;
   localparam int CELL_COUNT = COLUMNS * ROW_CAP;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   logic [15:0] cells_ff [CELL_COUNT];
   logic [15:0] rd_data_ff;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CNT_W-1:0]              keep_ff, keep_in;
   logic                          pend_ff, pend_in;
   logic [AW-1:0]                 wr_addr_ff, wr_addr_in;
   logic [txcw_pkg::COL_W-1:0]    col_ff, col_in;
   logic [txcw_pkg::ROW_W-1:0]    row_ff, row_in;
   txcw_pkg::txcw_rsp_type        out_ff, out_in;
   logic                          out_valid_ff, out_valid_in;

   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [15:0]                   mem_wdata;
   logic [AW-1:0]                 mem_raddr;

   logic [txcw_pkg::ROW_W-1:0]    rows_last;
   logic [txcw_pkg::ROW_W-1:0]    row_eff;
   logic                          nl_scroll;
   logic [txcw_pkg::ROW_W-1:0]    nl_row;
   logic [AW-1:0]                 put_addr;
   logic [AW-1:0]                 read_addr;
   logic [CNT_W-1:0]              copy_src;
   logic [CNT_W-1:0]              clear_end;
   logic                          out_free;
   logic                          scroll_now;
   logic                          do_new_line;

   assign rows_last = tall_mode ? txcw_pkg::ROW_W'(ROWS_TALL - 1)
                                : txcw_pkg::ROW_W'(ROWS_NORMAL - 1);
   assign row_eff   = (row_ff > rows_last) ? rows_last : row_ff;
   assign nl_scroll = (row_eff == rows_last);
   assign nl_row    = nl_scroll ? rows_last : row_eff + 1'b1;
   assign put_addr  = AW'(row_eff) * AW'(COLUMNS) + AW'(col_ff);
   assign read_addr = AW'(q_item.row) * AW'(COLUMNS) + AW'(q_item.col);
   assign copy_src  = cnt_ff + CNT_W'(COLUMNS);
   assign clear_end = keep_ff + CNT_W'(COLUMNS - 1);
   assign out_free  = !out_valid_ff || rsp_pop;

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
   assign init_busy = (state_ff == ST_INIT);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      keep_in      = keep_ff;
      pend_in      = 1'b0;
      wr_addr_in   = wr_addr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      mem_we       = 1'b0;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = 16'h0000;
      mem_raddr    = '0;
      q_pop        = 1'b0;
      scroll_now   = 1'b0;
      do_new_line  = 1'b0;

      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = {txcw_pkg::RESET_ATTR, 8'h00};
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               row_in = row_eff;
               case (q_item.op)
                  txcw_pkg::OP_PUT: begin
                     mem_we    = 1'b1;
                     mem_waddr = put_addr;
                     mem_wdata = {text_attr, q_item.char_code};
                     if (col_ff == txcw_pkg::COL_W'(COLUMNS - 1)) begin
                        do_new_line = 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  txcw_pkg::OP_LF: do_new_line = 1'b1;
                  txcw_pkg::OP_CR: col_in = '0;
                  txcw_pkg::OP_SET: begin
                     col_in = q_item.col;
                     row_in = q_item.row;
                  end
                  txcw_pkg::OP_READ: begin
                     mem_raddr = read_addr;
                     state_in  = ST_READ;
                  end
                  default: begin
                  end
               endcase
               if (do_new_line) begin
                  col_in = '0;
                  row_in = nl_row;
                  if (nl_scroll) begin
                     scroll_now = 1'b1;
                     keep_in    = CNT_W'(rows_last) * CNT_W'(COLUMNS);
                     cnt_in     = '0;
                     state_in   = ST_COPY;
                  end
               end
               out_in.cell_char  = 8'h00;
               out_in.cell_attr  = 8'h00;
               out_in.cursor_col = col_in;
               out_in.cursor_row = row_in;
               out_in.scrolled   = scroll_now;
               out_valid_in      = (q_item.op != txcw_pkg::OP_READ);
            end
         end
         ST_READ: begin
            out_in.cell_char = rd_data_ff[7:0];
            out_in.cell_attr = rd_data_ff[15:8];
            out_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_COPY: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = rd_data_ff;
            end
            if (cnt_ff < keep_ff) begin
               mem_raddr  = copy_src[AW-1:0];
               pend_in    = 1'b1;
               wr_addr_in = cnt_ff[AW-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end else begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = 16'h0000;
            if (cnt_ff == clear_end) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      keep_ff    <= keep_in;
      wr_addr_ff <= wr_addr_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cells_ff[mem_raddr];
   end

endmodule

// File: rtl/core/text_console_writer_unit.sv
// A put, set or control word reaches the result ports via the queue and result register, a
// read word also via the memory read register; the back takes one word per cycle while
// results are popped and no read or scroll is under way. A scroll holds the back for a
// copy pass and a clear pass. Reset is synchronous; afterwards a clearing pass writes all
// COLUMNS * max rows cells, 2560 by default, full high; configuration writes taken throughout.
// Top level of the text console writer; uses txcw_pkg, txcw_front and txcw_back.
module text_console_writer_unit #(
   parameter int COLUMNS     = 80,
   parameter int ROWS_TALL   = 32,
   parameter int ROWS_NORMAL = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [1:0]                      req_cmd,
   input  logic [7:0]                      req_char_code,
   input  logic [txcw_pkg::COL_W-1:0]      req_col,
   input  logic [txcw_pkg::ROW_PORT_W-1:0] req_row,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [7:0]                      rsp_cell_char,
   output logic [7:0]                      rsp_cell_attr,
   output logic [txcw_pkg::COL_W-1:0]      rsp_cursor_col,
   output logic [txcw_pkg::ROW_PORT_W-1:0] rsp_cursor_row,
   output logic                            rsp_scrolled,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [7:0]                      csr_wdata
);

   logic                    tall_mode_ff;
   logic [7:0]              text_attr_ff;
   logic                    init_busy;
   logic                    q_valid;
   logic                    q_pop;
   txcw_pkg::txcw_item_type q_item;
   logic                    rsp_valid;
   txcw_pkg::txcw_rsp_type  rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         tall_mode_ff <= 1'b0;
         text_attr_ff <= txcw_pkg::RESET_ATTR;
      end else if (csr_we) begin
         case (csr_index)
            txcw_pkg::CSR_TALL_MODE: tall_mode_ff <= csr_wdata[0];
            txcw_pkg::CSR_TEXT_ATTR: text_attr_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   txcw_front #(
      .COLUMNS     (COLUMNS),
      .ROWS_TALL   (ROWS_TALL),
      .ROWS_NORMAL (ROWS_NORMAL)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_col       (req_col),
      .req_row       (req_row),
      .tall_mode     (tall_mode_ff),
      .init_busy     (init_busy),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   txcw_back #(
      .COLUMNS     (COLUMNS),
      .ROWS_TALL   (ROWS_TALL),
      .ROWS_NORMAL (ROWS_NORMAL)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tall_mode (tall_mode_ff),
      .text_attr (text_attr_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_pop   (rsp_pop),
      .init_busy (init_busy)
   );

   assign rsp_empty      = !rsp_valid;
   assign rsp_cell_char  = rsp.cell_char;
   assign rsp_cell_attr  = rsp.cell_attr;
   assign rsp_cursor_col = rsp.cursor_col;
   assign rsp_cursor_row = rsp.cursor_row[txcw_pkg::ROW_PORT_W-1:0];
   assign rsp_scrolled   = rsp.scrolled;

endmodule

// File: rtl/core/txcw_checker.sv
// Port-level checker of the text console writer, bound to the top level.
// Depends on txcw_pkg and text_console_writer_unit_defines.svh.
`include "text_console_writer_unit_defines.svh"

module txcw_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_push,
   input logic                       req_full,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic [txcw_pkg::COL_W-1:0] rsp_cursor_col,
   input logic                       rsp_scrolled
);

   logic [2:0] owed_ff, owed_in;
   logic       word_in, word_out;

   assign word_in  = req_push && !req_full;
   assign word_out = rsp_pop && !rsp_empty;
   assign owed_in  = owed_ff + 3'(word_in) - 3'(word_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= 3'd0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   `TXCW_ASSERT_NEXT(a_empty_after_reset, clock, reset, rsp_empty)
   `TXCW_ASSERT_NEXT(a_result_held, clock, !reset && !rsp_empty && !rsp_pop, !rsp_empty)
   `TXCW_ASSERT_NOW(a_no_invented_word, clock, reset, !rsp_empty, owed_ff != 3'd0)
   `TXCW_ASSERT_NOW(a_owed_bounded, clock, reset, 1'b1, owed_ff <= 3'd4)
   `TXCW_ASSERT_NOW(a_scroll_home, clock, reset, !rsp_empty && rsp_scrolled, rsp_cursor_col == '0)

endmodule

bind text_console_writer_unit txcw_checker u_txcw_checker (.*);
